### rtl/spid_pkg.sv
package spid_pkg;

    // field and datapath widths
    localparam int TICK_BITS      = 16;
    localparam int GAIN_FRAC_BITS = 8;
    localparam int DUTY_FRAC      = 16;
    localparam int DUTY_SCALE     = 1000;
    localparam int SCALE_BITS     = 10;
    localparam int PROD_BITS      = TICK_BITS + SCALE_BITS;
    localparam int DUTY_W         = PROD_BITS + DUTY_FRAC;
    localparam int ROT_W          = 10;
    localparam int ANG_W          = 10;
    localparam int TGT_W          = 9;
    localparam int ERR_W          = 12;
    localparam int ESUM_W         = 7;
    localparam int GAIN_W         = 16;
    localparam int PULSE_W        = 11;
    localparam int ACC_W          = DUTY_W + ROT_W + 6;
    localparam int QBITS          = ANG_W + 2;
    localparam int MPROD_W        = ERR_W + GAIN_W;
    localparam int PID_W          = MPROD_W + 2;
    localparam int CNT_W          = $clog2(DUTY_W + 1);
    localparam int MAC_STEPS      = 4;

    // stream and register port widths
    localparam int IN_W      = ((2 * TICK_BITS + TGT_W + 7) / 8) * 8;
    localparam int OUT_W     = ((PULSE_W + ANG_W + ERR_W + 7) / 8) * 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;

    // control law constants
    localparam int DRIVE_LIMIT   = 200;
    localparam int DEADBAND      = 40;
    localparam int SUM_LIMIT     = 30;
    localparam int MIRROR_ANGLE  = 180;
    localparam int PULSE_NEUTRAL = 1500;
    localparam int PULSE_MIN     = PULSE_NEUTRAL - DRIVE_LIMIT - DEADBAND;
    localparam int PULSE_MAX     = PULSE_NEUTRAL + DRIVE_LIMIT + DEADBAND;
    localparam int DUTY_ONE      = 1 << DUTY_FRAC;

    // register reset values
    localparam int ROT_RESET  = 360;
    localparam int TMIN_RESET = 32;
    localparam int TMAX_RESET = 1068;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_ROT,
        CFG_MIN_HIGH,
        CFG_MAX_HIGH,
        CFG_GAIN_P,
        CFG_GAIN_I,
        CFG_GAIN_D
    } t_cfg_idx;

    typedef enum logic [1:0] {
        DS_MIN,
        DS_MAX,
        DS_HIGH
    } t_duty_sel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DUTY,
        S_DIFF,
        S_DEN,
        S_MUL,
        S_SIGN,
        S_NEGN,
        S_CHK,
        S_ADIV,
        S_ANG,
        S_ERR,
        S_MAC,
        S_FIN
    } t_state;

    // ticks * 1000 in fixed point with DUTY_FRAC fraction bits
    function automatic logic [DUTY_W-1:0] duty_num(input logic [TICK_BITS-1:0] ticks);
        logic [PROD_BITS-1:0] p;
        p = PROD_BITS'(ticks) * PROD_BITS'(DUTY_SCALE);
        return {p, {DUTY_FRAC{1'b0}}};
    endfunction

endpackage

### rtl/servo_position_pid.sv
// channel   | dir | handshake                    | payload
// s_axis    | in  | s_axis_tvalid/s_axis_tready  | cycle_ticks, high_ticks, target_angle
// m_axis    | out | m_axis_tvalid/m_axis_tready  | pulse_width, measured_angle, position_error
// cfg       | in  | i_cfg_we (no wait)           | i_cfg_idx, i_cfg_data
//
// one request runs, from accept to result, three restoring divisions for the
// duties, a shift-add multiply, an angle division and a multiply-accumulate,
// all on one shared 58-bit adder
// a zero period or a turn below two steps skips to the control law
// synchronous active-low reset restores register defaults and clears the integral
// the result sits in an output register, so the next request is taken while it waits
module servo_position_pid
    import spid_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [15:0] cycle_ticks, [31:16] high_ticks, [40:32] target_angle, rest zero
    input  logic [IN_W-1:0]      s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [10:0] pulse_width, [20:11] measured_angle, [32:21] position_error, rest zero
    output logic [OUT_W-1:0]     m_axis_tdata,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam logic signed [ERR_W:0]     ES_HI   = (ERR_W+1)'(SUM_LIMIT);
    localparam logic signed [ERR_W:0]     ES_LO   = -(ERR_W+1)'(SUM_LIMIT);
    localparam logic signed [PID_W-1:0]   DRV_HI  = PID_W'(DRIVE_LIMIT);
    localparam logic signed [PID_W-1:0]   DRV_LO  = -PID_W'(DRIVE_LIMIT);
    localparam logic [PID_W-1:0]          FRAC_MASK = PID_W'((1 << GAIN_FRAC_BITS) - 1);
    localparam logic signed [PULSE_W-1:0] DRV_POS = PULSE_W'(DRIVE_LIMIT);
    localparam logic signed [PULSE_W-1:0] DRV_NEG = -PULSE_W'(DRIVE_LIMIT);
    localparam logic signed [PULSE_W-1:0] OFS_POS = PULSE_W'(DEADBAND);
    localparam logic signed [PULSE_W-1:0] OFS_NEG = -PULSE_W'(DEADBAND);

    t_state    r_state, n_state;
    t_duty_sel r_sel;
    logic [CNT_W-1:0] r_cnt;

    // configuration
    logic [ROT_W-1:0]         r_rot;
    logic [TICK_BITS-1:0]     r_tmin, r_tmax;
    logic signed [GAIN_W-1:0] r_gp, r_gi, r_gd;

    // controller state
    logic signed [ESUM_W-1:0] r_esum;
    logic signed [ERR_W-1:0]  r_last;

    // request and working registers
    logic [TICK_BITS-1:0]     r_cycle, r_high;
    logic [TGT_W-1:0]         r_tgt;
    logic [TICK_BITS-1:0]     r_rem;
    logic [DUTY_W-1:0]        r_quo, r_dmin, r_dmax, r_dc;
    logic signed [ACC_W-1:0]  r_acc, r_mcand, r_den;
    logic [ROT_W-1:0]         r_mplier;
    logic [QBITS-1:0]         r_q;
    logic [ANG_W-1:0]         r_angle;
    logic signed [ERR_W-1:0]  r_err, r_deriv;
    logic signed [MPROD_W-1:0] r_prod;
    logic signed [PID_W-1:0]  r_sum;

    // output register
    logic                     r_ovalid;
    logic [PULSE_W-1:0]       r_pulse;
    logic [ANG_W-1:0]         r_oangle;
    logic [ERR_W-1:0]         r_oerr;

    // shared adder and multiplier
    logic signed [ACC_W-1:0]   u_a, u_b, u_y;
    logic                      u_sub, u_take;
    logic signed [ERR_W-1:0]   mul_a;
    logic signed [GAIN_W-1:0]  mul_b;
    logic signed [MPROD_W-1:0] mul_y;

    logic                  in_acc, out_load;
    logic [TICK_BITS-1:0]  in_cycle, in_high;
    logic [TGT_W-1:0]      in_tgt;
    logic [ROT_W-1:0]      top;
    logic [DUTY_W-1:0]     quo_next;
    logic [QBITS-2:0]      q_lo;
    logic [ANG_W-1:0]      ang_calc;
    logic signed [ERR_W-1:0] err_n, deriv_n;
    logic signed [ERR_W:0]   es_add;
    logic signed [ESUM_W-1:0] esum_n;
    logic signed [PID_W-1:0]  drv_sh, drv_t;
    logic                     drv_rnd;
    logic signed [PULSE_W-1:0] drive, offset;
    logic [PULSE_W-1:0]        pulse_n;

    assign in_cycle = s_axis_tdata[TICK_BITS-1:0];
    assign in_high  = s_axis_tdata[2*TICK_BITS-1:TICK_BITS];
    assign in_tgt   = s_axis_tdata[2*TICK_BITS+TGT_W-1:2*TICK_BITS];
    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign out_load = (r_state == S_FIN) && (!r_ovalid || m_axis_tready);
    assign top      = r_rot - 1'b1;

    // shared adder and sign test
    assign u_y    = u_sub ? (u_a - u_b) : (u_a + u_b);
    assign u_take = !u_y[ACC_W-1];
    assign mul_y  = mul_a * mul_b;

    assign quo_next = {r_quo[DUTY_W-2:0], u_take};

    // angle from the ceiling quotient, clamped at zero
    assign q_lo = r_q[QBITS-2:0];
    always_comb begin
        if (r_q[QBITS-1] || (q_lo >= (QBITS-1)'(top))) begin
            ang_calc = '0;
        end else begin
            ang_calc = top - q_lo[ANG_W-1:0] - 1'b1;
        end
    end

    // error, derivative and clamped integral, cleared when the error is zero
    assign err_n   = ERR_W'(MIRROR_ANGLE) - ERR_W'(r_tgt) - ERR_W'(r_angle);
    assign deriv_n = err_n - r_last;
    assign es_add  = (ERR_W+1)'(r_esum) + (ERR_W+1)'(err_n);
    always_comb begin
        if (err_n == '0) begin
            esum_n = '0;
        end else if (es_add > ES_HI) begin
            esum_n = ESUM_W'(ES_HI);
        end else if (es_add < ES_LO) begin
            esum_n = ESUM_W'(ES_LO);
        end else begin
            esum_n = ESUM_W'(es_add);
        end
    end

    // drive: truncate toward zero, clamp, add deadband offset
    assign drv_sh  = r_sum >>> GAIN_FRAC_BITS;
    assign drv_rnd = r_sum[PID_W-1] && ((r_sum & FRAC_MASK) != '0);
    assign drv_t   = drv_sh + PID_W'(drv_rnd);
    always_comb begin
        if (drv_t > DRV_HI) begin
            drive = DRV_POS;
        end else if (drv_t < DRV_LO) begin
            drive = DRV_NEG;
        end else begin
            drive = PULSE_W'(drv_t);
        end
        if (drive == '0) begin
            offset = '0;
        end else if (drive[PULSE_W-1]) begin
            offset = OFS_NEG;
        end else begin
            offset = OFS_POS;
        end
    end
    assign pulse_n = PULSE_W'(PULSE_NEUTRAL) + drive + offset;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = (in_cycle == '0 || r_rot < ROT_W'(2)) ? S_ERR : S_DUTY;
                end
            end
            S_DUTY: begin
                if (r_cnt == CNT_W'(DUTY_W - 1) && r_sel == DS_HIGH) begin
                    n_state = S_DIFF;
                end
            end
            S_DIFF: n_state = S_DEN;
            S_DEN:  n_state = S_MUL;
            S_MUL: begin
                if (r_cnt == CNT_W'(ROT_W - 1)) begin
                    n_state = S_SIGN;
                end
            end
            S_SIGN: begin
                if (r_den == '0) begin
                    n_state = S_ERR;
                end else if (r_den[ACC_W-1]) begin
                    n_state = S_NEGN;
                end else begin
                    n_state = S_CHK;
                end
            end
            S_NEGN: n_state = S_CHK;
            S_CHK: begin
                n_state = (r_acc[ACC_W-1] || r_acc == '0) ? S_ERR : S_ADIV;
            end
            S_ADIV: begin
                if (r_cnt == CNT_W'(QBITS - 1)) begin
                    n_state = S_ANG;
                end
            end
            S_ANG: n_state = S_ERR;
            S_ERR: n_state = S_MAC;
            S_MAC: begin
                if (r_cnt == CNT_W'(MAC_STEPS - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer: handshake and operand selection
    always_comb begin
        s_axis_tready = 1'b0;
        u_a   = '0;
        u_b   = '0;
        u_sub = 1'b1;
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_IDLE: s_axis_tready = 1'b1;
            S_DUTY: begin
                u_a = ACC_W'({r_rem, r_quo[DUTY_W-1]});
                u_b = ACC_W'(r_cycle);
            end
            S_DIFF: begin
                u_a = ACC_W'(r_dc);
                u_b = ACC_W'(r_dmin);
            end
            S_DEN: begin
                u_a = ACC_W'(r_dmax) + ACC_W'(DUTY_ONE);
                u_b = ACC_W'(r_dmin);
            end
            S_MUL: begin
                u_a   = r_acc;
                u_b   = r_mcand;
                u_sub = 1'b0;
            end
            S_SIGN: u_b = r_den;
            S_NEGN: u_b = r_acc;
            S_CHK: begin
                u_a = r_acc;
                u_b = ACC_W'(1);
            end
            S_ADIV: begin
                u_a = r_acc;
                u_b = r_den;
            end
            S_MAC: begin
                u_a   = ACC_W'(r_sum);
                u_b   = ACC_W'(r_prod);
                u_sub = 1'b0;
                case (r_cnt)
                    CNT_W'(0): begin
                        mul_a = r_err;
                        mul_b = r_gp;
                    end
                    CNT_W'(1): begin
                        mul_a = ERR_W'(r_esum);
                        mul_b = r_gi;
                    end
                    CNT_W'(2): begin
                        mul_a = r_deriv;
                        mul_b = r_gd;
                    end
                    default: begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            default: ;
        endcase
    end

    // control, configuration and controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_sel    <= DS_MIN;
            r_cnt    <= '0;
            r_rot    <= ROT_W'(ROT_RESET);
            r_tmin   <= TICK_BITS'(TMIN_RESET);
            r_tmax   <= TICK_BITS'(TMAX_RESET);
            r_gp     <= '0;
            r_gi     <= '0;
            r_gd     <= '0;
            r_esum   <= '0;
            r_last   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;

            // register writes
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_MAX_ROT:  r_rot  <= i_cfg_data[ROT_W-1:0];
                    CFG_MIN_HIGH: r_tmin <= i_cfg_data[TICK_BITS-1:0];
                    CFG_MAX_HIGH: r_tmax <= i_cfg_data[TICK_BITS-1:0];
                    CFG_GAIN_P:   r_gp   <= i_cfg_data;
                    CFG_GAIN_I:   r_gi   <= i_cfg_data;
                    CFG_GAIN_D:   r_gd   <= i_cfg_data;
                    default: ;
                endcase
            end

            // step counter and duty select
            case (r_state)
                S_IDLE: begin
                    r_cnt <= '0;
                    r_sel <= DS_MIN;
                end
                S_DUTY: begin
                    if (r_cnt == CNT_W'(DUTY_W - 1)) begin
                        r_cnt <= '0;
                        r_sel <= (r_sel == DS_MIN) ? DS_MAX : DS_HIGH;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_MUL, S_ADIV, S_MAC: r_cnt <= r_cnt + 1'b1;
                default: r_cnt <= '0;
            endcase

            // integral and last error
            if (r_state == S_ERR) begin
                r_esum <= esum_n;
            end
            if (out_load) begin
                r_last <= r_err;
            end

            // output valid
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_cycle <= in_cycle;
                    r_high  <= in_high;
                    r_tgt   <= in_tgt;
                    r_quo   <= duty_num(r_tmin);
                    r_rem   <= '0;
                    r_angle <= '0;
                end
            end
            // restoring division, one quotient bit a cycle
            S_DUTY: begin
                if (r_cnt == CNT_W'(DUTY_W - 1)) begin
                    case (r_sel)
                        DS_MIN:  r_dmin <= quo_next;
                        DS_MAX:  r_dmax <= quo_next;
                        default: r_dc   <= quo_next;
                    endcase
                    r_rem <= '0;
                    r_quo <= duty_num((r_sel == DS_MIN) ? r_tmax : r_high);
                end else begin
                    r_rem <= u_take ? u_y[TICK_BITS-1:0]
                                    : {r_rem[TICK_BITS-2:0], r_quo[DUTY_W-1]};
                    r_quo <= quo_next;
                end
            end
            S_DIFF: begin
                r_mcand  <= u_y;
                r_acc    <= '0;
                r_mplier <= r_rot;
            end
            S_DEN: r_den <= u_y;
            // shift-add multiply by the turn size
            S_MUL: begin
                if (r_mplier[0]) begin
                    r_acc <= u_y;
                end
                r_mcand  <= r_mcand <<< 1;
                r_mplier <= r_mplier >> 1;
            end
            // degenerate or negative denominator
            S_SIGN: begin
                if (r_den == '0) begin
                    r_angle <= r_acc[ACC_W-1] ? top : '0;
                end else if (r_den[ACC_W-1]) begin
                    r_den <= u_y;
                end
            end
            S_NEGN: r_acc <= u_y;
            S_CHK: begin
                if (r_acc[ACC_W-1] || r_acc == '0) begin
                    r_angle <= top;
                end else begin
                    r_acc <= u_y;
                    r_den <= r_den <<< (QBITS - 1);
                    r_q   <= '0;
                end
            end
            // bounded quotient of (n - 1) / d
            S_ADIV: begin
                if (u_take) begin
                    r_acc <= u_y;
                end
                r_q   <= {r_q[QBITS-2:0], u_take};
                r_den <= r_den >>> 1;
            end
            S_ANG: r_angle <= ang_calc;
            S_ERR: begin
                r_err   <= err_n;
                r_deriv <= deriv_n;
                r_sum   <= '0;
            end
            // products registered, then accumulated
            S_MAC: begin
                if (r_cnt != CNT_W'(MAC_STEPS - 1)) begin
                    r_prod <= mul_y;
                end
                if (r_cnt != '0) begin
                    r_sum <= u_y[PID_W-1:0];
                end
            end
            S_FIN: begin
                if (out_load) begin
                    r_pulse  <= pulse_n;
                    r_oangle <= r_angle;
                    r_oerr   <= r_err;
                end
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = OUT_W'({r_oerr, r_oangle, r_pulse});

    // integral never leaves its clamp
    a_esum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_esum <= ESUM_W'(SUM_LIMIT)) && (r_esum >= -ESUM_W'(SUM_LIMIT)))
        else $error("integral out of range");

    // a delivered pulse stays within neutral plus drive and deadband
    a_pulse_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_pulse >= PULSE_W'(PULSE_MIN)) && (r_pulse <= PULSE_W'(PULSE_MAX)))
        else $error("pulse out of range");

    // measured angle below the turn size
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_oangle < r_rot) || (r_oangle == '0))
        else $error("angle out of range");

    // a request is taken one at a time
    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request accepted while busy");

    // reset empties the output register
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule
